// ===== hw/rtl/smms_pkg.sv =====
// ----------------------------------------------------------------------------
// smms_pkg: shared types and codes for the shared memory multi-stack unit
// Holds the result status codes, controller states and the command and
// status structs that pass between controller and datapath.
// ----------------------------------------------------------------------------
package smms_pkg;

    typedef enum logic [1:0] {
        ST_DONE  = 2'd0,
        ST_FULL  = 2'd1,
        ST_EMPTY = 2'd2
    } status_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_DECIDE,
        S_SHIFT_RD,
        S_SHIFT_WR,
        S_ADJUST,
        S_EXEC,
        S_POP_RD,
        S_OUT
    } state_t;

    typedef struct packed {
        logic load;
        logic decide;
        logic shift_rd;
        logic shift_wr;
        logic adjust;
        logic exec;
        logic pop_rd;
        logic finish;
    } cmd_t;

    typedef struct packed {
        logic refused;
        logic need_shift;
        logic is_pop;
        logic shift_last;
    } stat_t;

endpackage

// ===== hw/rtl/shared_memory_multi_stack_unit.sv =====
// ----------------------------------------------------------------------------
// shared_memory_multi_stack_unit: several stacks sharing one memory
// Top level joining the controller, the datapath and the stream ports.
// ----------------------------------------------------------------------------
// A plain push passes the decide and execute states before its result is valid,
// a pop also a pop read state, a refused request the decide state only. A push
// into a locally full stack first runs the shift loop, a read and a write state
// per shifted word, then a last read and the adjust state. One item is in flight
// at a time; the next input transfer is taken the cycle after the result transfer.
// Reset (synchronous, active low) splits the memory evenly.
module shared_memory_multi_stack_unit #(
    parameter int MEM_DEPTH  = 256,
    parameter int NUM_STACKS = 4
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    // tdata: [0] mode, [2:1] stack_index, [34:3] push_value, rest zero
    input  logic [39:0] s_tdata,
    output logic        m_tvalid,
    input  logic        m_tready,
    // tdata: [31:0] pop_value, [33:32] status, rest zero
    output logic [39:0] m_tdata,
    input  logic        cfg_we,
    input  logic [8:0]  cfg_wdata
);

    smms_pkg::cmd_t  cmd;
    smms_pkg::stat_t st;
    logic            busy;
    logic [8:0]      reserve_reg;
    logic [31:0]     pop_value;
    logic [1:0]      status;
    logic            out_valid_reg;

    // The user must write the reserve setting only while the unit is idle; the block does not enforce it.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            reserve_reg <= '0;
        end else if (cfg_we) begin
            reserve_reg <= cfg_wdata;
        end
    end

    assign s_tready = !busy;

    smms_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .in_fire  (s_tvalid && s_tready),
        .out_fire (m_tvalid && m_tready),
        .st       (st),
        .cmd      (cmd),
        .busy     (busy)
    );

    smms_dp #(
        .MEM_DEPTH  (MEM_DEPTH),
        .NUM_STACKS (NUM_STACKS)
    ) u_dp (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cmd           (cmd),
        .st            (st),
        .in_mode       (s_tdata[0]),
        .in_index      (s_tdata[2:1]),
        .in_value      (s_tdata[34:3]),
        .reserve       (reserve_reg),
        .res_pop_value (pop_value),
        .res_status    (status)
    );

    // The result is valid from the cycle after execution or refusal
    // until its transfer completes.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (m_tvalid && m_tready) begin
            out_valid_reg <= 1'b0;
        end else if (cmd.exec || (cmd.decide && st.refused)) begin
            out_valid_reg <= 1'b1;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata = {6'd0, status, pop_value};

endmodule

// ===== hw/rtl/smms_ctrl.sv =====
// ----------------------------------------------------------------------------
// smms_ctrl: controller of the shared memory multi-stack unit
// Sequences decision, word shifting, pointer update, pop read and the result transfer.
// ----------------------------------------------------------------------------
module smms_ctrl (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             in_fire,
    input  logic             out_fire,
    input  smms_pkg::stat_t  st,
    output smms_pkg::cmd_t   cmd,
    output logic             busy
);

    smms_pkg::state_t state_reg, state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= smms_pkg::S_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            smms_pkg::S_IDLE: begin
                if (in_fire) state_next = smms_pkg::S_DECIDE;
            end
            smms_pkg::S_DECIDE: begin
                if (st.refused) state_next = smms_pkg::S_OUT;
                else if (st.is_pop) state_next = smms_pkg::S_POP_RD;
                else if (st.need_shift) state_next = smms_pkg::S_SHIFT_RD;
                else state_next = smms_pkg::S_EXEC;
            end
            smms_pkg::S_SHIFT_RD: begin
                if (st.shift_last) state_next = smms_pkg::S_ADJUST;
                else state_next = smms_pkg::S_SHIFT_WR;
            end
            smms_pkg::S_SHIFT_WR: state_next = smms_pkg::S_SHIFT_RD;
            smms_pkg::S_ADJUST:   state_next = smms_pkg::S_EXEC;
            smms_pkg::S_POP_RD:   state_next = smms_pkg::S_EXEC;
            smms_pkg::S_EXEC:     state_next = smms_pkg::S_OUT;
            smms_pkg::S_OUT: begin
                if (out_fire) state_next = smms_pkg::S_IDLE;
            end
            default: state_next = smms_pkg::S_IDLE;
        endcase
    end

    always_comb begin
        cmd = '0;
        busy = 1'b1;
        unique case (state_reg)
            smms_pkg::S_IDLE: begin
                busy = 1'b0;
                cmd.load = in_fire;
            end
            smms_pkg::S_DECIDE:   cmd.decide = 1'b1;
            smms_pkg::S_SHIFT_RD: cmd.shift_rd = 1'b1;
            smms_pkg::S_SHIFT_WR: cmd.shift_wr = 1'b1;
            smms_pkg::S_ADJUST:   cmd.adjust = 1'b1;
            smms_pkg::S_POP_RD:   cmd.pop_rd = 1'b1;
            smms_pkg::S_EXEC:     cmd.exec = 1'b1;
            smms_pkg::S_OUT:      cmd.finish = out_fire;
            default:              busy = 1'b1;
        endcase
    end

endmodule

// ===== hw/rtl/smms_dp.sv =====
// ----------------------------------------------------------------------------
// smms_dp: datapath of the shared memory multi-stack unit
// Holds the shared store, the stack pointers, the used count and the result.
// Pointers are kept one above their architectural value so -1 maps to 0.
// ----------------------------------------------------------------------------
module smms_dp #(
    parameter int MEM_DEPTH  = 256,
    parameter int NUM_STACKS = 4,
    parameter int PW         = $clog2(MEM_DEPTH + 1),
    parameter int AW         = $clog2(MEM_DEPTH),
    parameter int SW         = (NUM_STACKS > 1) ? $clog2(NUM_STACKS) : 1
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  smms_pkg::cmd_t   cmd,
    output smms_pkg::stat_t  st,
    input  logic             in_mode,
    input  logic [1:0]       in_index,
    input  logic [31:0]      in_value,
    input  logic [8:0]       reserve,
    output logic [31:0]      res_pop_value,
    output logic [1:0]       res_status
);

    localparam int SEG = MEM_DEPTH / NUM_STACKS;

    // Stored pointer = architectural pointer + 1.
    logic [PW-1:0] bot_reg [NUM_STACKS+1];
    logic [PW-1:0] top_reg [NUM_STACKS];
    logic [PW-1:0] used_reg;
    logic [31:0]   mem [MEM_DEPTH];

    logic          mode_reg;
    logic [1:0]    idx_reg;
    logic [31:0]   val_reg;
    logic [31:0]   rd_reg;
    logic [31:0]   pop_reg;
    logic [1:0]    status_reg;
    logic          refused_reg, shift_reg_f, right_reg;
    logic [SW-1:0] tgt_reg;
    logic [PW-1:0] ptr_reg, end_reg;

    logic [SW-1:0] s;
    logic          idx_ok;
    logic [PW-1:0] t_s;
    logic          found_r, found_l;
    logic [SW-1:0] jr, jl;
    logic          full_local;
    logic [PW:0]   free_cnt;

    assign idx_ok = ({30'd0, idx_reg} < NUM_STACKS);
    assign s = idx_reg[SW-1:0];
    assign t_s = top_reg[s];
    assign full_local = (t_s == bot_reg[s+1]);
    assign free_cnt = (PW+1)'(MEM_DEPTH) - {1'b0, used_reg};

    always_comb begin
        found_r = 1'b0;
        jr = '0;
        for (int j = NUM_STACKS - 1; j >= 0; j--) begin
            if (j > int'(s) && top_reg[j] < bot_reg[j+1]) begin
                found_r = 1'b1;
                jr = SW'(j);
            end
        end
        found_l = 1'b0;
        jl = '0;
        for (int j = 0; j < NUM_STACKS; j++) begin
            if (j < int'(s) && top_reg[j] < bot_reg[j+1]) begin
                found_l = 1'b1;
                jl = SW'(j);
            end
        end
    end

    always_comb begin
        st.is_pop = mode_reg;
        st.refused = 1'b0;
        st.need_shift = 1'b0;
        if (mode_reg) begin
            st.refused = !idx_ok || (t_s == bot_reg[s]);
        end else begin
            st.refused = !idx_ok || (free_cnt <= {1'b0, reserve})
                         || (full_local && !found_r && !found_l);
            st.need_shift = full_local;
        end
        // Right shift walks down from the target top to the pushed stack's top; left walks up.
        st.shift_last = right_reg ? (ptr_reg == end_reg) : (ptr_reg > end_reg);
    end

    always_ff @(posedge aclk) begin
        if (cmd.shift_rd && !st.shift_last) begin
            rd_reg <= right_reg ? mem[AW'(ptr_reg - 1'b1)] : mem[AW'(ptr_reg - 1'b1)];
        end
        if (cmd.shift_wr) begin
            if (right_reg) mem[AW'(ptr_reg)] <= rd_reg;
            else mem[AW'(ptr_reg - 2'd2)] <= rd_reg;
        end
        if (cmd.pop_rd) begin
            rd_reg <= mem[AW'(t_s - 1'b1)];
        end
        if (cmd.exec && !mode_reg) mem[AW'(t_s)] <= val_reg;
        if (cmd.exec && mode_reg) mem[AW'(t_s - 1'b1)] <= 32'd0;
    end

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            mode_reg <= in_mode;
            idx_reg <= in_index;
            val_reg <= in_value;
        end
        if (cmd.decide) begin
            refused_reg <= st.refused;
            shift_reg_f <= st.need_shift;
            right_reg <= found_r;
            tgt_reg <= found_r ? jr : jl;
            pop_reg <= 32'd0;
            status_reg <= mode_reg ? smms_pkg::ST_EMPTY : smms_pkg::ST_FULL;
            if (found_r) begin
                ptr_reg <= top_reg[jr];
                end_reg <= t_s;
            end else begin
                ptr_reg <= bot_reg[jl+1] + 1'b1;
                end_reg <= t_s;
            end
        end
        if (cmd.shift_wr) begin
            ptr_reg <= right_reg ? ptr_reg - 1'b1 : ptr_reg + 1'b1;
        end
        if (cmd.exec) begin
            status_reg <= smms_pkg::ST_DONE;
            pop_reg <= mode_reg ? rd_reg : 32'd0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < NUM_STACKS; i++) begin
                bot_reg[i] <= PW'(SEG * i);
                top_reg[i] <= PW'(SEG * i);
            end
            bot_reg[NUM_STACKS] <= PW'(MEM_DEPTH);
            used_reg <= '0;
        end else begin
            if (cmd.adjust) begin
                for (int k = 0; k < NUM_STACKS; k++) begin
                    if (right_reg && k > int'(s) && k <= int'(tgt_reg)) begin
                        bot_reg[k] <= bot_reg[k] + 1'b1;
                        top_reg[k] <= top_reg[k] + 1'b1;
                    end
                    if (!right_reg && k > int'(tgt_reg) && k <= int'(s)) begin
                        bot_reg[k] <= bot_reg[k] - 1'b1;
                        top_reg[k] <= top_reg[k] - 1'b1;
                    end
                end
            end
            if (cmd.exec) begin
                if (mode_reg) begin
                    top_reg[s] <= t_s - 1'b1;
                    if (used_reg != '0) used_reg <= used_reg - 1'b1;
                end else begin
                    top_reg[s] <= t_s + 1'b1;
                    used_reg <= used_reg + 1'b1;
                end
            end
        end
    end

    assign res_pop_value = pop_reg;
    assign res_status = status_reg;

    logic unused;
    assign unused = refused_reg ^ shift_reg_f;

endmodule

// ===== hw/rtl/smms_checker.sv =====
// ----------------------------------------------------------------------------
// smms_checker: port-level assertions for the multi-stack unit
// Checks one-at-a-time behavior, result encoding and result stability seen at the ports.
// ----------------------------------------------------------------------------
module smms_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [39:0] m_tdata
);

    a_no_accept_while_result: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> !s_tready) else $error("input taken while result pending");

    a_busy_after_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready) |=> !s_tready) else $error("second input taken in flight");

    a_status_code: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tdata[33:32] != 2'd3)) else $error("bad status code");

    a_zero_on_refuse: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tdata[33:32] != 2'd0) |-> (m_tdata[31:0] == 32'd0))
        else $error("refused result carries data");

    a_result_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata)))
        else $error("result changed while stalled");

endmodule

bind shared_memory_multi_stack_unit smms_checker u_smms_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);
